// ===== src/hsfc_pkg.sv =====
// hsfc_pkg: shared types, codes and the CRC-8 step function for the
// humidity sensor frame checker. No dependencies.
package hsfc_pkg;

    localparam int HSFC_FRAME_LEN   = 6;
    localparam int HSFC_QUEUE_DEPTH = 2;

    // input item kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_TEMP_MIN = 2'd0;
    localparam logic [1:0] CFG_TEMP_MAX = 2'd1;
    localparam logic [1:0] CFG_HUM_MIN  = 2'd2;
    localparam logic [1:0] CFG_HUM_MAX  = 2'd3;

    // conversion constants
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] DIV_CONST   = 17'd65535;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_CRC   = 3'd2,
        ST_RANGE = 3'd3,
        ST_ZERO  = 3'd4
    } status_t;

    // one finished transfer handed from front to back
    typedef struct packed {
        logic [2:0]                          count;
        logic [HSFC_FRAME_LEN-1:0][7:0]      bytes;
    } job_t;

    typedef struct packed {
        logic [14:0] temp_min;
        logic [14:0] temp_max;
        logic [13:0] hum_min;
        logic [13:0] hum_max;
    } limits_t;

    // CRC-8 over one byte already xored into the register, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== src/humidity_sensor_frame_checker_unit.sv =====
// humidity_sensor_frame_checker_unit: top level with the limit registers,
// front end, transfer queue and decode pipeline. Depends on hsfc_pkg,
// hsfc_front, hsfc_queue and hsfc_back.
//
// Usage:
//   Input channel (byte_valid / byte_stall): each transfer carries either a
//   data byte (kind = 0, rx_byte) or an end marker (kind = 1). The input
//   stalls, for data bytes and end markers alike, only while the transfer
//   queue is full.
//   Output channel (result_valid / result_stall): one result per end marker.
//   The end marker's job passes through the queue write, the first CRC step,
//   the CRC check + multiply, the divide and the result register, in order.
//   Throughput: one input transfer per cycle while the queue is not full;
//   results can also leave one per cycle when not stalled. The pipeline
//   advances as one whenever the result register is empty or being taken.
//   When the receiver stalls, the result holds and the pipeline freezes;
//   the queue absorbs QUEUE_DEPTH end markers before the input stalls.
//   Data bytes keep being taken into the frame store until then. Reset:
//   byte count zero, queue and pipeline empty, limits at their defaults
//   (-20.00 C .. 80.00 C, 0.00 % .. 100.00 %). Limits are written through
//   cfg_we/cfg_index/cfg_data only while idle; only the user enforces this.
module humidity_sensor_frame_checker_unit
    import hsfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = HSFC_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic        kind,
    input  logic [7:0]  rx_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [2:0]  byte_count,
    output logic        frame_ok,
    output logic [15:0] temp_raw,
    output logic [15:0] raw_hum,
    output logic        temp_crc_ok,
    output logic        hum_crc_ok,
    output logic [14:0] temp_centi,
    output logic [13:0] hum_centi,
    output logic        in_range
);

    limits_t limits_reg;
    logic    push, full, pop, not_empty;
    job_t    push_job, head;

    // limit registers; all four indexes are defined
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limits_reg.temp_min <= -15'sd2000;
            limits_reg.temp_max <= 15'sd8000;
            limits_reg.hum_min  <= 14'd0;
            limits_reg.hum_max  <= 14'd10000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TEMP_MIN: limits_reg.temp_min <= cfg_data;
                CFG_TEMP_MAX: limits_reg.temp_max <= cfg_data;
                CFG_HUM_MIN:  limits_reg.hum_min  <= cfg_data[13:0];
                CFG_HUM_MAX:  limits_reg.hum_max  <= cfg_data[13:0];
                default:      limits_reg          <= limits_reg;
            endcase
        end
    end

    hsfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .kind       (kind),
        .rx_byte    (rx_byte),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    hsfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    hsfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .head         (head),
        .pop          (pop),
        .limits       (limits_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .byte_count   (byte_count),
        .frame_ok     (frame_ok),
        .temp_raw     (temp_raw),
        .raw_hum      (raw_hum),
        .temp_crc_ok  (temp_crc_ok),
        .hum_crc_ok   (hum_crc_ok),
        .temp_centi   (temp_centi),
        .hum_centi    (hum_centi),
        .in_range     (in_range)
    );

endmodule

// ===== src/hsfc_front.sv =====
// hsfc_front: accepts bytes and end markers, keeps the first six bytes and
// a saturating count, and hands a job to the queue at each end marker.
// Depends on hsfc_pkg.
module hsfc_front
    import hsfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    input  logic       queue_full,
    output logic       push,
    output job_t       push_job
);

    logic [HSFC_FRAME_LEN-1:0][7:0] store_reg;
    logic [2:0]                     count_reg;
    logic [2:0]                     count_next;
    logic                           xfer;

    assign byte_stall = queue_full;
    assign xfer       = byte_valid && !byte_stall;
    assign push       = xfer && (kind == KIND_END);

    assign push_job.count = count_reg;
    assign push_job.bytes = store_reg;

    always_comb
    begin
        count_next = count_reg;
        if (xfer) begin
            if (kind == KIND_END)
                count_next = 3'd0;
            else if (count_reg != 3'd7)
                count_next = count_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 3'd0;
        else
            count_reg <= count_next;
    end

    // bytes past the sixth are dropped
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HSFC_FRAME_LEN; i++) begin
            if (xfer && kind == KIND_DATA && count_reg == 3'(i))
                store_reg[i] <= rx_byte;
        end
    end

endmodule

// ===== src/hsfc_queue.sv =====
// hsfc_queue: small FIFO of finished transfers between front and back.
// Depends on hsfc_pkg.
module hsfc_queue
    import hsfc_pkg::*;
#(
    parameter int DEPTH = HSFC_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] fill_reg;

    assign full      = (fill_reg == CW'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== src/hsfc_back.sv =====
// hsfc_back: four-stage pipeline that checks CRCs, converts the words and
// tests limits; the last stage is the result register. Depends on hsfc_pkg.
module hsfc_back
    import hsfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        not_empty,
    input  job_t        head,
    output logic        pop,
    input  limits_t     limits,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [2:0]  byte_count,
    output logic        frame_ok,
    output logic [15:0] temp_raw,
    output logic [15:0] raw_hum,
    output logic        temp_crc_ok,
    output logic        hum_crc_ok,
    output logic [14:0] temp_centi,
    output logic [13:0] hum_centi,
    output logic        in_range
);

    logic adv;

    // stage 1: first CRC byte step
    logic        s1_valid_reg;
    job_t        s1_job_reg;
    logic [7:0]  s1_ct_reg, s1_ch_reg;
    // stage 2: CRC compare and products
    logic        s2_valid_reg;
    logic [2:0]  s2_count_reg;
    logic [15:0] s2_raw_t_reg, s2_raw_h_reg;
    logic        s2_tcrc_reg, s2_hcrc_reg;
    logic [30:0] s2_prod_t_reg;
    logic [29:0] s2_prod_h_reg;
    // stage 3: divide by 65535
    logic        s3_valid_reg;
    logic [2:0]  s3_count_reg;
    logic [15:0] s3_raw_t_reg, s3_raw_h_reg;
    logic        s3_tcrc_reg, s3_hcrc_reg;
    logic [14:0] s3_temp_reg;
    logic [13:0] s3_hum_reg;
    // result register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [2:0]  out_count_reg;
    logic        out_frame_ok_reg;
    logic [15:0] out_raw_t_reg, out_raw_h_reg;
    logic        out_tcrc_reg, out_hcrc_reg;
    logic [14:0] out_temp_reg;
    logic [13:0] out_hum_reg;
    logic        out_inr_reg;

    // stage 3 combinational
    logic [14:0] q0_t, qt;
    logic [13:0] q0_h, qh;
    logic [16:0] r_t, r_h;
    // result combinational
    logic        f_ok, crc_ok, inr;
    status_t     st;

    // whole pipeline moves together whenever the result slot can take data
    assign adv = !out_valid_reg || !result_stall;
    assign pop = adv && not_empty;

    // floor(x / 65535): quotient estimate x>>16, one correction step
    assign q0_t = s2_prod_t_reg[30:16];
    assign r_t  = 17'(s2_prod_t_reg[15:0]) + 17'(q0_t);
    assign qt   = q0_t + 15'(r_t >= DIV_CONST);
    assign q0_h = 14'(s2_prod_h_reg[29:16]);
    assign r_h  = 17'(s2_prod_h_reg[15:0]) + 17'(q0_h);
    assign qh   = q0_h + 14'(r_h >= DIV_CONST);

    always_comb
    begin
        f_ok   = (s3_count_reg == 3'(HSFC_FRAME_LEN));
        crc_ok = s3_tcrc_reg && s3_hcrc_reg;
        inr    = crc_ok
                 && ($signed(s3_temp_reg) >= $signed(limits.temp_min))
                 && ($signed(s3_temp_reg) <= $signed(limits.temp_max))
                 && (s3_hum_reg >= limits.hum_min)
                 && (s3_hum_reg <= limits.hum_max);
        priority if (!f_ok)
            st = ST_SHORT;
        else if (!crc_ok)
            st = ST_CRC;
        else if (inr)
            st = ST_OK;
        else if (s3_raw_t_reg == 16'd0 && s3_raw_h_reg == 16'd0)
            st = ST_ZERO;
        else
            st = ST_RANGE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= not_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_job_reg <= head;
            s1_ct_reg  <= crc8_byte(head.bytes[0] ^ CRC_INIT);
            s1_ch_reg  <= crc8_byte(head.bytes[3] ^ CRC_INIT);

            s2_count_reg  <= s1_job_reg.count;
            s2_raw_t_reg  <= {s1_job_reg.bytes[0], s1_job_reg.bytes[1]};
            s2_raw_h_reg  <= {s1_job_reg.bytes[3], s1_job_reg.bytes[4]};
            s2_tcrc_reg   <= (s1_job_reg.bytes[2] ==
                              crc8_byte(s1_ct_reg ^ s1_job_reg.bytes[1]));
            s2_hcrc_reg   <= (s1_job_reg.bytes[5] ==
                              crc8_byte(s1_ch_reg ^ s1_job_reg.bytes[4]));
            s2_prod_t_reg <= 31'({s1_job_reg.bytes[0], s1_job_reg.bytes[1]}) * 31'(TEMP_SPAN);
            s2_prod_h_reg <= 30'({s1_job_reg.bytes[3], s1_job_reg.bytes[4]}) * 30'(HUM_SPAN);

            s3_count_reg <= s2_count_reg;
            s3_raw_t_reg <= s2_raw_t_reg;
            s3_raw_h_reg <= s2_raw_h_reg;
            s3_tcrc_reg  <= s2_tcrc_reg;
            s3_hcrc_reg  <= s2_hcrc_reg;
            s3_temp_reg  <= qt - TEMP_OFFSET;
            s3_hum_reg   <= qh;

            // short frames report zeros; CRC failures keep raw words and flags
            out_status_reg   <= st;
            out_count_reg    <= s3_count_reg;
            out_frame_ok_reg <= f_ok;
            out_raw_t_reg    <= f_ok ? s3_raw_t_reg : 16'd0;
            out_raw_h_reg    <= f_ok ? s3_raw_h_reg : 16'd0;
            out_tcrc_reg     <= f_ok && s3_tcrc_reg;
            out_hcrc_reg     <= f_ok && s3_hcrc_reg;
            out_temp_reg     <= (f_ok && crc_ok) ? s3_temp_reg : 15'd0;
            out_hum_reg      <= (f_ok && crc_ok) ? s3_hum_reg : 14'd0;
            out_inr_reg      <= f_ok && inr;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign byte_count   = out_count_reg;
    assign frame_ok     = out_frame_ok_reg;
    assign temp_raw     = out_raw_t_reg;
    assign raw_hum      = out_raw_h_reg;
    assign temp_crc_ok  = out_tcrc_reg;
    assign hum_crc_ok   = out_hcrc_reg;
    assign temp_centi   = out_temp_reg;
    assign hum_centi    = out_hum_reg;
    assign in_range     = out_inr_reg;

endmodule

// ===== sim/hsfc_frame_checker.sv =====
`timescale 1ns / 100ps
// hsfc_frame_checker: sensor CRC helper package and the scoreboard that predicts and
// checks every result of humidity_sensor_frame_checker_unit. Depends on hsfc_pkg.
package hsfc_tb_util_pkg;

    localparam int TEMP_FLOOR = -4500;
    localparam int TEMP_RANGE = 17500;
    localparam int HUM_RANGE  = 10000;
    localparam int RAW_FULL   = 65535;

    // CRC-8 of one 16-bit word, bitwise, MSB first
    function automatic logic [7:0] sensor_crc8(input logic [15:0] word);
        logic [7:0] crc;
        crc = hsfc_pkg::CRC_INIT;
        for (int i = 15; i >= 0; i--)
        begin
            if (crc[7] ^ word[i])
                crc = {crc[6:0], 1'b0} ^ hsfc_pkg::CRC_POLY;
            else
                crc = {crc[6:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

module hsfc_frame_checker
    import hsfc_pkg::*;
    import hsfc_tb_util_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic        kind,
    input  logic [7:0]  rx_byte,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [2:0]  status,
    input  logic [2:0]  byte_count,
    input  logic        frame_ok,
    input  logic [15:0] temp_raw,
    input  logic [15:0] raw_hum,
    input  logic        temp_crc_ok,
    input  logic        hum_crc_ok,
    input  logic [14:0] temp_centi,
    input  logic [13:0] hum_centi,
    input  logic        in_range,
    output int          fail_count,
    output int          pending
);

    localparam logic [2:0] COUNT_SAT = 3'd7;

    typedef struct {
        status_t     status;
        logic [2:0]  byte_count;
        logic        frame_ok;
        logic [15:0] temp_raw;
        logic [15:0] raw_hum;
        logic        temp_crc_ok;
        logic        hum_crc_ok;
        logic [14:0] temp_centi;
        logic [13:0] hum_centi;
        logic        in_range;
    } reading_t;

    logic [7:0] rx_bytes [HSFC_FRAME_LEN];
    logic [2:0] rx_total;
    limits_t    lim;
    reading_t   readings_due [$];
    int         n_results;

    task automatic log_mismatch(input string what);
        $display("%0t ns  frame check: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                   n_results, name, got, want));
    endtask

    // decode the transfer collected so far against the current limits
    function automatic reading_t decode_transfer();
        reading_t r;
        int       t_val;
        int       h_val;
        r.status      = ST_SHORT;
        r.byte_count  = rx_total;
        r.frame_ok    = (rx_total == 3'(HSFC_FRAME_LEN));
        r.temp_raw    = '0;
        r.raw_hum     = '0;
        r.temp_crc_ok = 1'b0;
        r.hum_crc_ok  = 1'b0;
        r.temp_centi  = '0;
        r.hum_centi   = '0;
        r.in_range    = 1'b0;
        if (r.frame_ok)
        begin
            r.temp_raw    = {rx_bytes[0], rx_bytes[1]};
            r.raw_hum     = {rx_bytes[3], rx_bytes[4]};
            r.temp_crc_ok = (rx_bytes[2] == sensor_crc8(r.temp_raw));
            r.hum_crc_ok  = (rx_bytes[5] == sensor_crc8(r.raw_hum));
            if (!(r.temp_crc_ok && r.hum_crc_ok))
                r.status = ST_CRC;
            else
            begin
                t_val = TEMP_FLOOR + (TEMP_RANGE * int'(r.temp_raw)) / RAW_FULL;
                h_val = (HUM_RANGE * int'(r.raw_hum)) / RAW_FULL;
                r.temp_centi = t_val[14:0];
                r.hum_centi  = h_val[13:0];
                r.in_range   = (t_val >= int'($signed(lim.temp_min))) &&
                               (t_val <= int'($signed(lim.temp_max))) &&
                               (h_val >= int'(lim.hum_min)) &&
                               (h_val <= int'(lim.hum_max));
                if (r.in_range)
                    r.status = ST_OK;
                else if (r.temp_raw == 16'h0000 && r.raw_hum == 16'h0000)
                    r.status = ST_ZERO;
                else
                    r.status = ST_RANGE;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        reading_t want;
        if (!rst_n)
        begin
            foreach (rx_bytes[i])
                rx_bytes[i] = 8'h00;
            rx_total     = '0;
            lim.temp_min = 15'(-2000);
            lim.temp_max = 15'd8000;
            lim.hum_min  = 14'd0;
            lim.hum_max  = 14'd10000;
            readings_due.delete();
            n_results    = 0;
            fail_count   = 0;
            pending      = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (readings_due.size() == 0)
                    log_mismatch($sformatf("result %0d arrived with none outstanding",
                                           n_results));
                else
                begin
                    want = readings_due.pop_front();
                    check_field("status", status, want.status);
                    check_field("byte_count", byte_count, want.byte_count);
                    check_field("frame_ok", frame_ok, want.frame_ok);
                    check_field("temp_raw", temp_raw, want.temp_raw);
                    check_field("raw_hum", raw_hum, want.raw_hum);
                    check_field("temp_crc_ok", temp_crc_ok, want.temp_crc_ok);
                    check_field("hum_crc_ok", hum_crc_ok, want.hum_crc_ok);
                    check_field("temp_centi", temp_centi, want.temp_centi);
                    check_field("hum_centi", hum_centi, want.hum_centi);
                    check_field("in_range", in_range, want.in_range);
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TEMP_MIN: lim.temp_min = cfg_data;
                    CFG_TEMP_MAX: lim.temp_max = cfg_data;
                    CFG_HUM_MIN:  lim.hum_min  = cfg_data[13:0];
                    CFG_HUM_MAX:  lim.hum_max  = cfg_data[13:0];
                    default: ;
                endcase
            end

            if (byte_valid && !byte_stall)
            begin
                if (kind == KIND_DATA)
                begin
                    if (rx_total < 3'(HSFC_FRAME_LEN))
                        rx_bytes[rx_total] = rx_byte;
                    if (rx_total != COUNT_SAT)
                        rx_total = rx_total + 3'd1;
                end
                else
                begin
                    readings_due.push_back(decode_transfer());
                    rx_total = '0;
                end
            end

            pending = readings_due.size();
        end
    end

endmodule

// ===== sim/humidity_sensor_frame_checker_unit_tb.sv =====
`timescale 1ns / 100ps
// humidity_sensor_frame_checker_unit_tb: stimulus and verdict for the frame checker.
// Depends on hsfc_pkg, hsfc_tb_util_pkg, hsfc_frame_checker and the unit itself.
module humidity_sensor_frame_checker_unit_tb
    import hsfc_pkg::*;
    import hsfc_tb_util_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        byte_valid;
    logic        byte_stall;
    logic        kind;
    logic [7:0]  rx_byte;
    logic        result_valid;
    logic        result_stall;
    logic [2:0]  status;
    logic [2:0]  byte_count;
    logic        frame_ok;
    logic [15:0] temp_raw;
    logic [15:0] raw_hum;
    logic        temp_crc_ok;
    logic        hum_crc_ok;
    logic [14:0] temp_centi;
    logic [13:0] hum_centi;
    logic        in_range;

    int fail_count;     // from the checker
    int pending;        // results predicted but not yet seen on the output

    // stimulus bookkeeping
    int items_sent;
    int t_lo, t_hi, h_lo, h_hi;     // limits as last written, used to aim readings
    bit burst;                      // when set, the sender never idles

    humidity_sensor_frame_checker_unit uut (.*);

    hsfc_frame_checker checker_i (.*);

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run (every transfer after the
    // longest sender gap, every result behind the longest receiver stall).
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Raw word for one channel whose converted value is base + floor(span*raw/65535).
    // A good share is aimed right at a limit (one below, on, one above) so the
    // range compare is exercised at its edges; the rest are extremes or random.
    function automatic logic [15:0] pick_raw(input int lo, input int hi,
                                             input int base, input int span);
        int r;
        int target;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'h0000;
        if (r < 14)
            return 16'hFFFF;
        if (r < 45)
        begin
            target = (r[0] ? lo : hi) + int'($urandom_range(0, 2)) - 1;
            if (target < base)
                target = base;
            if (target > base + span)
                target = base + span;
            // smallest raw whose converted value reaches target
            return 16'(((target - base) * RAW_FULL + span - 1) / span);
        end
        return 16'($urandom);
    endfunction

    // append one sensor word: MSB, LSB, CRC (optionally corrupted by crc_flip)
    function automatic void add_word(ref logic [7:0] frame [$], input logic [15:0] word,
                                     input logic [7:0] crc_flip);
        frame.push_back(word[15:8]);
        frame.push_back(word[7:0]);
        frame.push_back(sensor_crc8(word) ^ crc_flip);
    endfunction

    // Present one item and hold it until the transfer happens.
    // byte_stall is read right after the edge, i.e. the value that edge used.
    task automatic push_item(input logic item_kind, input logic [7:0] item_byte);
        byte_valid <= 1'b1;
        kind       <= item_kind;
        rx_byte    <= item_byte;
        do
            @(posedge clk);
        while (byte_stall);
    endtask

    task automatic sender_gap();
        int n;
        n = burst ? 0 : pick_gap();
        if (n > 0)
        begin
            byte_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // data bytes of one sensor read, then the end marker
    task automatic send_transfer(input logic [7:0] frame [$]);
        foreach (frame[i])
        begin
            push_item(KIND_DATA, frame[i]);
            sender_gap();
        end
        push_item(KIND_END, 8'($urandom));
        sender_gap();
        items_sent += frame.size() + 1;
    endtask

    // Stop sending and wait until every predicted result has come out.
    task automatic drain();
        byte_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write all four limit registers; only ever done with the unit idle.
    task automatic set_limits(input int tmin, input int tmax, input int hmin, input int hmax);
        logic [1:0] regs [4];
        int         vals [4];
        regs = '{CFG_TEMP_MIN, CFG_TEMP_MAX, CFG_HUM_MIN, CFG_HUM_MAX};
        vals = '{tmin, tmax, hmin, hmax};
        drain();
        cfg_we <= 1'b1;
        foreach (regs[i])
        begin
            cfg_index <= regs[i];
            cfg_data  <= 15'(vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        t_lo = tmin;
        t_hi = tmax;
        h_lo = hmin;
        h_hi = hmax;
    endtask

    // One random sensor read. Most are well formed with correct CRCs so they
    // reach the conversion and range logic; the rest carry bad CRCs or the
    // wrong number of bytes.
    task automatic random_transfer();
        logic [7:0]  frame [$];
        logic [15:0] t_word;
        logic [15:0] h_word;
        int          r;
        int          which;
        burst  = ($urandom_range(0, 7) == 0);
        r      = $urandom_range(0, 99);
        t_word = pick_raw(t_lo, t_hi, TEMP_FLOOR, TEMP_RANGE);
        h_word = pick_raw(h_lo, h_hi, 0, HUM_RANGE);
        if (r < 5)
        begin
            // all-zero reading, the way a dead sensor answers
            t_word = 16'h0000;
            h_word = 16'h0000;
        end
        if (r < 78)
        begin
            add_word(frame, t_word, 8'h00);
            add_word(frame, h_word, 8'h00);
        end
        else if (r < 88)
        begin
            // one or both CRC bytes wrong
            which = $urandom_range(1, 3);
            add_word(frame, t_word, which[0] ? 8'($urandom_range(1, 255)) : 8'h00);
            add_word(frame, h_word, which[1] ? 8'($urandom_range(1, 255)) : 8'h00);
        end
        else if (r < 95)
        begin
            repeat ($urandom_range(0, 5)) frame.push_back(8'($urandom));
        end
        else
        begin
            // too many bytes: count saturates at 7
            repeat ($urandom_range(7, 10)) frame.push_back(8'($urandom));
        end
        send_transfer(frame);
        // now and then hold off until the result pipeline is empty
        if ($urandom_range(0, 49) == 0)
            drain();
    endtask

    task automatic run_items(input int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
            random_transfer();
    endtask

    // Receiver pacing: stall spells alternate with ready spells; some ready
    // spells are long so results also stream out back to back.
    initial
    begin : receiver_pacing
        bit stall_on;
        int span;
        stall_on = 1'b0;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall_on = !stall_on;
            if (stall_on)
                span = pick_gap();
            else
                span = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 150)
                                                   : $urandom_range(1, 5);
            if (span > 0)
            begin
                result_stall <= stall_on;
                repeat (span) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0] frame [$];
        int         t_pt;
        int         h_pt;

        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_TEMP_MIN;
        cfg_data   <= '0;
        byte_valid <= 1'b0;
        kind       <= KIND_DATA;
        rx_byte    <= 8'h00;
        items_sent = 0;
        burst      = 1'b0;
        // reset values of the limit registers
        t_lo = -2000;
        t_hi = 8000;
        h_lo = 0;
        h_hi = 10000;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, with the limits at their reset values ---
        // end marker with no bytes at all: short frame
        send_transfer(frame);
        // seven bytes, alternating extremes: count saturates, frame is short
        for (int i = 0; i < 7; i++)
            frame.push_back(i[0] ? 8'hFF : 8'h00);
        send_transfer(frame);
        // all-zero reading with good CRCs: out of range, reported as zero frame
        frame.delete();
        add_word(frame, 16'h0000, 8'h00);
        add_word(frame, 16'h0000, 8'h00);
        send_transfer(frame);
        // full-scale words, humidity CRC off by one bit: CRC failure
        frame.delete();
        add_word(frame, 16'hFFFF, 8'h00);
        add_word(frame, 16'hFFFF, 8'h01);
        send_transfer(frame);
        // sender holds off until every result is out
        drain();

        // --- random phases, each under its own limits ---
        run_items(180);

        // widest limits
        set_limits(TEMP_FLOOR, TEMP_FLOOR + TEMP_RANGE, 0, HUM_RANGE);
        run_items(180);

        // crossed limits: nothing can be in range
        set_limits(8000, -2000, 9000, 1000);
        run_items(100);

        // single-point window on each channel
        t_pt = int'($urandom_range(0, TEMP_RANGE)) + TEMP_FLOOR;
        h_pt = $urandom_range(0, HUM_RANGE);
        set_limits(t_pt, t_pt, h_pt, h_pt);
        run_items(100);

        // random windows, crossed or not
        repeat (3)
        begin
            set_limits(int'($urandom_range(0, TEMP_RANGE)) + TEMP_FLOOR,
                       int'($urandom_range(0, TEMP_RANGE)) + TEMP_FLOOR,
                       $urandom_range(0, HUM_RANGE), $urandom_range(0, HUM_RANGE));
            run_items(130);
        end

        drain();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
src/hsfc_pkg.sv
src/hsfc_front.sv
src/hsfc_queue.sv
src/hsfc_back.sv
src/humidity_sensor_frame_checker_unit.sv
sim/hsfc_frame_checker.sv
sim/humidity_sensor_frame_checker_unit_tb.sv
